// ----- src/tdbs_pkg.sv -----
`default_nettype none
package tdbs_pkg;

   localparam int DELAY_BITS_DEFAULT = 10;
   localparam int DELAY_RESET        = 100;
   localparam logic [7:0] LSB_MASK   = 8'b0000_0001;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START     = 4'd1,
      PH_BIT_A     = 4'd2,
      PH_BIT_B     = 4'd3,
      PH_BIT_HIGH  = 4'd4,
      PH_ACK_LOW   = 4'd5,
      PH_ACK_WAIT  = 4'd6,
      PH_ACK_HIGH  = 4'd7,
      PH_ACK_TAIL  = 4'd8,
      PH_WAIT_BYTE = 4'd9,
      PH_STOP_A    = 4'd10,
      PH_STOP_B    = 4'd11,
      PH_STOP_C    = 4'd12
   } tdbs_phase_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_OFFER = 1'b1
   } tdbs_op_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       end_of_frame;
      logic       dio_sample;
   } tdbs_item_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic ready_for_byte;
      logic byte_accepted;
      logic ack_missing;
   } tdbs_result_type;

endpackage
`default_nettype wire

// ----- src/tdbs_if.sv -----
`default_nettype none
interface tdbs_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       end_of_frame;
   logic       dio_sample;

   modport source (output valid, operation, data_byte, end_of_frame, dio_sample,
                   input ready);
   modport sink   (input valid, operation, data_byte, end_of_frame, dio_sample,
                   output ready);
endinterface

interface tdbs_rsp_if;
   logic valid;
   logic ready;
   logic clk_level;
   logic dio_level;
   logic dio_drive;
   logic ready_for_byte;
   logic byte_accepted;
   logic ack_missing;

   modport source (output valid, clk_level, dio_level, dio_drive, ready_for_byte,
                   byte_accepted, ack_missing, input ready);
   modport sink   (input valid, clk_level, dio_level, dio_drive, ready_for_byte,
                   byte_accepted, ack_missing, output ready);
endinterface

interface tdbs_csr_if #(parameter int W = 10);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/two_wire_display_byte_sender.sv -----
// Two-wire display byte sender.
// Path: a request beat is taken into the input register, and its result then
// goes to the result register, where it waits until rsp_chan takes it.
// Throughput: one request beat per cycle unless rsp_chan stalls; line timing
// comes from tick beats counted against delay_ticks, not from clock cycles.
// Reset: synchronous; lines go idle high and driven, delay_ticks returns to 100.
`default_nettype none
module two_wire_display_byte_sender #(
   parameter int DELAY_BITS = tdbs_pkg::DELAY_BITS_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   tdbs_req_if.sink   req_chan,
   tdbs_rsp_if.source rsp_chan,
   tdbs_csr_if.sink   csr_chan
);
   import tdbs_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   tdbs_item_type         item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   tdbs_result_type       res_ff, res_in;
   logic [DELAY_BITS-1:0] delay_ff;
   logic                  advance, step;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign step           = in_valid_ff && advance;
   assign csr_chan.ready = 1'b1;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= DELAY_BITS'(DELAY_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            delay_ff <= csr_chan.data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.operation    <= req_chan.operation;
         item_ff.data_byte    <= req_chan.data_byte;
         item_ff.end_of_frame <= req_chan.end_of_frame;
         item_ff.dio_sample   <= req_chan.dio_sample;
      end
      if (step) begin
         res_ff <= res_in;
      end
   end

   tdbs_core #(
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item_ff),
      .delay_ticks (delay_ff),
      .result      (res_in)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.clk_level      = res_ff.clk_level;
   assign rsp_chan.dio_level      = res_ff.dio_level;
   assign rsp_chan.dio_drive      = res_ff.dio_drive;
   assign rsp_chan.ready_for_byte = res_ff.ready_for_byte;
   assign rsp_chan.byte_accepted  = res_ff.byte_accepted;
   assign rsp_chan.ack_missing    = res_ff.ack_missing;

endmodule
`default_nettype wire

// ----- src/tdbs_core.sv -----
`default_nettype none
module tdbs_core #(
   parameter int DELAY_BITS = 10
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       step,
   input  wire tdbs_pkg::tdbs_item_type item,
   input  wire [DELAY_BITS-1:0]      delay_ticks,
   output tdbs_pkg::tdbs_result_type result
);
   import tdbs_pkg::*;

   tdbs_phase_type        phase_ff, phase_in;
   logic [2:0]            bit_index_ff, bit_index_in;
   logic [7:0]            shift_ff, shift_in;
   logic [DELAY_BITS-1:0] tick_ff, tick_in;
   logic                  last_ff, last_in;
   logic                  ack_ff, ack_in;
   logic                  clk_ff, clk_in;
   logic                  dio_ff, dio_in;
   logic                  en_ff, en_in;

   logic                  idle_now, idle_next;
   logic [DELAY_BITS-1:0] len_raw, len_eff, tick_inc;
   logic                  accepted, missing;

   assign idle_now = (phase_ff == PH_IDLE) || (phase_ff > PH_STOP_C);
   assign len_raw  = ((phase_ff == PH_BIT_A) || (phase_ff == PH_BIT_B)) ?
                     (delay_ticks >> 1) : delay_ticks;
   assign len_eff  = (len_raw == '0) ? DELAY_BITS'(1) : len_raw;
   assign tick_inc = tick_ff + DELAY_BITS'(1);

   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      tick_in      = tick_ff;
      last_in      = last_ff;
      ack_in       = ack_ff;
      clk_in       = clk_ff;
      dio_in       = dio_ff;
      en_in        = en_ff;
      accepted     = 1'b0;
      missing      = 1'b0;
      if (step) begin
         if (item.operation == OP_OFFER) begin
            if (idle_now || phase_ff == PH_WAIT_BYTE) begin
               accepted     = 1'b1;
               shift_in     = item.data_byte;
               bit_index_in = 3'd0;
               last_in      = item.end_of_frame;
               en_in        = 1'b1;
               tick_in      = '0;
               if (idle_now) begin
                  clk_in   = 1'b1;
                  dio_in   = 1'b0;
                  phase_in = PH_START;
               end else begin
                  clk_in   = 1'b0;
                  phase_in = PH_BIT_A;
               end
            end
         end else if (!idle_now && phase_ff != PH_WAIT_BYTE) begin
            if (phase_ff == PH_ACK_WAIT && !item.dio_sample) begin
               ack_in = 1'b1;
            end
            tick_in = tick_inc;
            // phase ends when the count wraps or reaches its length
            if (tick_inc == '0 || tick_inc >= len_eff) begin
               tick_in = '0;
               case (phase_ff)
                  PH_START: begin
                     clk_in   = 1'b0;
                     phase_in = PH_BIT_A;
                  end
                  PH_BIT_A: begin
                     dio_in   = |(shift_ff & LSB_MASK);
                     phase_in = PH_BIT_B;
                  end
                  PH_BIT_B: begin
                     shift_in = shift_ff >> 1;
                     clk_in   = 1'b1;
                     phase_in = PH_BIT_HIGH;
                  end
                  PH_BIT_HIGH: begin
                     clk_in = 1'b0;
                     if (bit_index_ff != 3'd7) begin
                        bit_index_in = bit_index_ff + 3'd1;
                        phase_in     = PH_BIT_A;
                     end else begin
                        bit_index_in = 3'd0;
                        en_in        = 1'b0;
                        ack_in       = 1'b0;
                        phase_in     = PH_ACK_LOW;
                     end
                  end
                  PH_ACK_LOW: begin
                     clk_in   = 1'b1;
                     phase_in = PH_ACK_WAIT;
                  end
                  PH_ACK_WAIT: begin
                     missing  = !ack_in;
                     phase_in = PH_ACK_HIGH;
                  end
                  PH_ACK_HIGH: begin
                     clk_in   = 1'b0;
                     phase_in = PH_ACK_TAIL;
                  end
                  PH_ACK_TAIL: begin
                     en_in = 1'b1;
                     if (last_ff) begin
                        dio_in   = 1'b0;
                        phase_in = PH_STOP_A;
                     end else begin
                        phase_in = PH_WAIT_BYTE;
                     end
                  end
                  PH_STOP_A: begin
                     clk_in   = 1'b1;
                     phase_in = PH_STOP_B;
                  end
                  PH_STOP_B: begin
                     dio_in   = 1'b1;
                     phase_in = PH_STOP_C;
                  end
                  default: begin
                     last_in  = 1'b0;
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   assign idle_next = (phase_in == PH_IDLE) || (phase_in > PH_STOP_C);

   always_comb begin
      result.clk_level      = clk_in;
      result.dio_level      = dio_in;
      result.dio_drive      = en_in;
      result.ready_for_byte = idle_next || (phase_in == PH_WAIT_BYTE);
      result.byte_accepted  = accepted;
      result.ack_missing    = missing;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= 3'd0;
         shift_ff     <= 8'd0;
         tick_ff      <= '0;
         last_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         clk_ff       <= 1'b1;
         dio_ff       <= 1'b1;
         en_ff        <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         last_ff      <= last_in;
         ack_ff       <= ack_in;
         clk_ff       <= clk_in;
         dio_ff       <= dio_in;
         en_ff        <= en_in;
      end
   end

   // data line released only across the ack slot
   a_release_in_ack: assert property (@(posedge clock) disable iff (reset)
      !en_ff |-> (phase_ff == PH_ACK_LOW || phase_ff == PH_ACK_WAIT ||
                  phase_ff == PH_ACK_HIGH || phase_ff == PH_ACK_TAIL))
      else $error("data line released outside ack slot");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (step && accepted) |=> (phase_ff == PH_START || phase_ff == PH_BIT_A))
      else $error("accepted byte did not start a transfer");

   a_missing_on_tick: assert property (@(posedge clock) disable iff (reset)
      missing |-> (step && !accepted && phase_ff == PH_ACK_WAIT))
      else $error("ack_missing outside ack window close");

   a_bit_clock_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BIT_A || phase_ff == PH_BIT_B) |-> !clk_ff)
      else $error("clock high while data may change");

endmodule
`default_nettype wire
